@@ src/fmqd_pkg.sv @@
// ----------------------------------------------------------------------------
// FM quadrature demodulator package
// Shared widths, register codes, reset values, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fmqd_pkg;

    localparam int FIELD_W    = 16;
    localparam int AUDIO_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 15;
    localparam int DECIM_W    = 7;
    localparam int ALPHA_W    = 16;
    localparam int ACC_W      = 24;
    localparam int COUNT_W    = 6;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd7000;
    localparam logic [DECIM_W-1:0] DECIM_RESET = 7'd16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd1311;
    localparam logic [DECIM_W-1:0] DECIM_MAX   = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUDIO_GAIN   = 2'd0,
        CFG_DECIMATION   = 2'd1,
        CFG_FILTER_ALPHA = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PW1,
        ST_PW2,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_FILT1,
        ST_FILT2,
        ST_GAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic pw1;
        logic pw2;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic mul1;
        logic mul2;
        logic filt1;
        logic filt2;
        logic gain;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic emit_due;
        logic out_free;
    } status_t;

endpackage

@@ src/fmqd_ifs.sv @@
// ----------------------------------------------------------------------------
// FM quadrature demodulator channel interfaces
// Sample input, audio output and configuration write channels.
// ----------------------------------------------------------------------------
interface fmqd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fmqd_pkg::FIELD_W-1:0] sample_i;
    logic signed [fmqd_pkg::FIELD_W-1:0] sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fmqd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fmqd_pkg::AUDIO_W-1:0] audio_sample;

    modport source (output valid, output audio_sample, input ready);
    modport sink   (input valid, input audio_sample, output ready);
endinterface

interface fmqd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [fmqd_pkg::CFG_IDX_W-1:0]       index;
    logic [fmqd_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/fmqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// FM quadrature demodulator controller
// Sequences one sample through power, square root, limiter division,
// discriminator and lowpass steps, then audio gain and emit when audio is due.
// ----------------------------------------------------------------------------
module fmqd_ctrl #(
    parameter int SAMPLE_BITS    = 16,
    parameter int NORM_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fmqd_pkg::status_t  status,
    output fmqd_pkg::cmd_t     cmd
);

    localparam int RW   = SAMPLE_BITS + 8;
    localparam int QW   = NORM_FRAC_BITS + 2;
    localparam int MAXI = (RW > QW) ? RW : QW;
    localparam int CNTW = $clog2(MAXI);

    fmqd_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmqd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            fmqd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fmqd_pkg::ST_PW1;
                end
            end
            fmqd_pkg::ST_PW1:
            begin
                state_next = fmqd_pkg::ST_PW2;
            end
            fmqd_pkg::ST_PW2:
            begin
                state_next = fmqd_pkg::ST_SQRT;
                cnt_next   = CNTW'(RW - 1);
            end
            fmqd_pkg::ST_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = fmqd_pkg::ST_DIV_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            fmqd_pkg::ST_DIV_INIT:
            begin
                state_next = fmqd_pkg::ST_DIV;
                cnt_next   = CNTW'(QW - 1);
            end
            fmqd_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = fmqd_pkg::ST_MUL1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            fmqd_pkg::ST_MUL1:
            begin
                state_next = fmqd_pkg::ST_MUL2;
            end
            fmqd_pkg::ST_MUL2:
            begin
                state_next = fmqd_pkg::ST_FILT1;
            end
            fmqd_pkg::ST_FILT1:
            begin
                state_next = fmqd_pkg::ST_FILT2;
            end
            fmqd_pkg::ST_FILT2:
            begin
                state_next = status.emit_due ? fmqd_pkg::ST_GAIN : fmqd_pkg::ST_IDLE;
            end
            fmqd_pkg::ST_GAIN:
            begin
                state_next = fmqd_pkg::ST_EMIT;
            end
            fmqd_pkg::ST_EMIT:
            begin
                // hold until the output register can take the request
                if (status.out_free)
                begin
                    state_next = fmqd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmqd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            fmqd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            fmqd_pkg::ST_PW1:      cmd.pw1       = 1'b1;
            fmqd_pkg::ST_PW2:      cmd.pw2       = 1'b1;
            fmqd_pkg::ST_SQRT:     cmd.sqrt_step = 1'b1;
            fmqd_pkg::ST_DIV_INIT: cmd.div_init  = 1'b1;
            fmqd_pkg::ST_DIV:      cmd.div_step  = 1'b1;
            fmqd_pkg::ST_MUL1:     cmd.mul1      = 1'b1;
            fmqd_pkg::ST_MUL2:     cmd.mul2      = 1'b1;
            fmqd_pkg::ST_FILT1:    cmd.filt1     = 1'b1;
            fmqd_pkg::ST_FILT2:    cmd.filt2     = 1'b1;
            fmqd_pkg::ST_GAIN:     cmd.gain      = 1'b1;
            fmqd_pkg::ST_EMIT:     cmd.emit      = status.out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/fmqd_datapath.sv @@
// ----------------------------------------------------------------------------
// FM quadrature demodulator datapath
// Bit-serial square root, two-lane restoring divider for the limiter,
// conjugate-product discriminator, one-pole lowpass, decimator, audio gain,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module fmqd_datapath #(
    parameter int SAMPLE_BITS    = 16,
    parameter int NORM_FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [fmqd_pkg::FIELD_W-1:0] sample_i,
    input  logic signed [fmqd_pkg::FIELD_W-1:0] sample_q,
    input  fmqd_pkg::cmd_t                      cmd,
    output fmqd_pkg::status_t                   status,
    fmqd_out_if.source                          audio,
    fmqd_cfg_if.sink                            cfg
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = NORM_FRAC_BITS;
    localparam int RW  = S + 8;
    localparam int VW  = 2 * S + 16;
    localparam int DW  = RW + 4;
    localparam int QW  = F + 2;
    localparam int CW  = DW + QW;
    localparam int NB  = F + 1;
    localparam int DMW = 2 * NB + 1;
    localparam int SH  = 2 * F - 23;
    localparam int LS  = (SH < 0) ? -SH : 0;
    localparam int XW  = DMW + LS + 26;
    localparam int AW  = fmqd_pkg::ACC_W;

    localparam logic signed [XW-1:0] X_MAX = XW'(8388607);
    localparam logic signed [XW-1:0] X_MIN = XW'(-8388608);
    localparam logic [QW-1:0] Q_ONE = QW'(1) << F;

    // sample and square root
    logic signed [S-1:0]   si_reg, si_next, sq_reg, sq_next;
    logic [2*S-1:0]        sqi_reg, sqi_next;
    logic [VW-1:0]         v_reg, v_next;
    logic [RW:0]           rsq_reg, rsq_next;
    logic [RW-1:0]         root_reg, root_next;
    // divider lanes
    logic [CW-1:0]         dsh_reg, dsh_next;
    logic [CW-1:0]         remi_reg, remi_next, remq_reg, remq_next;
    logic [QW-1:0]         qi_reg, qi_next, qq_reg, qq_next;
    // discriminator and filter
    logic signed [2*NB-1:0] p1_reg, p1_next;
    logic signed [DMW-1:0]  demod_reg, demod_next;
    logic signed [NB-1:0]   prev_i_reg, prev_i_next, prev_q_reg, prev_q_next;
    logic signed [41:0]     fprod_reg, fprod_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic [fmqd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic signed [39:0]     gprod_reg, gprod_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [fmqd_pkg::AUDIO_W-1:0] out_data_reg, out_data_next;
    // configuration
    logic [fmqd_pkg::GAIN_W-1:0]  gain_reg, gain_next;
    logic [fmqd_pkg::DECIM_W-1:0] decim_reg, decim_next;
    logic [fmqd_pkg::ALPHA_W-1:0] alpha_reg, alpha_next;

    // combinational terms
    logic signed [2*S-1:0]  pi, pq;
    logic [2*S-1:0]         pw_sum;
    logic [RW+1:0]          rem_t, trial;
    logic [DW-1:0]          den;
    logic [S-1:0]           mag_i, mag_q;
    logic [CW-1:0]          num_i, num_q;
    logic signed [NB-1:0]   ni, nq;
    logic signed [2*NB-1:0] m1, m2;
    logic signed [XW-1:0]   d_pre, d_sat;
    logic signed [AW-1:0]   d23;
    logic signed [AW:0]     diff;
    logic signed [41:0]     fm;
    logic                   fneg;
    logic [41:0]            fmag, fr;
    logic signed [43:0]     stp, asum;
    logic signed [AW-1:0]   acc_upd;
    logic signed [39:0]     gm;
    logic                   gneg;
    logic [39:0]            gmag, ga;
    logic signed [40:0]     gs;
    logic signed [fmqd_pkg::AUDIO_W-1:0] audio_val;
    logic [fmqd_pkg::DECIM_W-1:0] dec_eff, cnt_inc;

    function automatic logic signed [NB-1:0] limit_comp(
        input logic [QW-1:0] q,
        input logic          neg
    );
        logic [QW-1:0] capped;
        if (neg)
        begin
            capped     = (q > Q_ONE) ? Q_ONE : q;
            limit_comp = -$signed(NB'(capped));
        end
        else
        begin
            capped     = (q > Q_ONE - 1'b1) ? Q_ONE - 1'b1 : q;
            limit_comp = $signed(NB'(capped));
        end
    endfunction

    assign pi     = si_reg * si_reg;
    assign pq     = sq_reg * sq_reg;
    assign pw_sum = sqi_reg + $unsigned(pq);
    assign rem_t  = {rsq_reg[RW-1:0], v_reg[VW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign den    = DW'(16'd8192) + DW'({root_reg, 2'b00}) + DW'(root_reg);
    assign mag_i  = si_reg[S-1] ? S'(-si_reg) : S'(si_reg);
    assign mag_q  = sq_reg[S-1] ? S'(-sq_reg) : S'(sq_reg);
    assign num_i  = CW'(CW'(mag_i) * CW'(11'd1280)) << F;
    assign num_q  = CW'(CW'(mag_q) * CW'(11'd1280)) << F;
    assign ni     = limit_comp(qi_reg, si_reg[S-1]);
    assign nq     = limit_comp(qq_reg, sq_reg[S-1]);
    assign m1     = nq * prev_i_reg;
    assign m2     = ni * prev_q_reg;

    // rescale the discriminator to 23 fraction bits
    generate
        if (SH > 0)
        begin : g_shr
            localparam logic [DMW:0] HALF = (DMW+1)'(1) << (SH - 1);
            logic              dneg;
            logic [DMW-1:0]    dmag;
            logic [DMW:0]      rsum;
            logic signed [DMW+1:0] rsg;
            assign dneg  = demod_reg[DMW-1];
            assign dmag  = dneg ? DMW'(-demod_reg) : DMW'(demod_reg);
            assign rsum  = ({1'b0, dmag} + HALF) >> SH;
            assign rsg   = dneg ? -$signed({1'b0, rsum}) : $signed({1'b0, rsum});
            assign d_pre = XW'(rsg);
        end
        else
        begin : g_shl
            logic signed [XW-1:0] dx, dxs;
            assign dx    = XW'(demod_reg);
            assign dxs   = (dx > X_MAX) ? X_MAX : ((dx < X_MIN) ? X_MIN : dx);
            assign d_pre = dxs <<< LS;
        end
    endgenerate

    assign d_sat = (d_pre > X_MAX) ? X_MAX : ((d_pre < X_MIN) ? X_MIN : d_pre);
    assign d23   = d_sat[AW-1:0];
    assign diff  = (AW+1)'(d23) - (AW+1)'(acc_reg);
    assign fm    = diff * $signed({1'b0, alpha_reg});

    assign fneg    = fprod_reg[41];
    assign fmag    = fneg ? 42'(-fprod_reg) : 42'(fprod_reg);
    assign fr      = (fmag + 42'd32768) >> 16;
    assign stp     = fneg ? -$signed(44'(fr)) : $signed(44'(fr));
    assign asum    = stp + 44'(acc_reg);
    assign acc_upd = (asum > 44'sd8388607) ? 24'sh7fffff :
                     ((asum < -44'sd8388608) ? 24'sh800000 : asum[AW-1:0]);

    assign gm        = acc_reg * $signed({1'b0, gain_reg});
    assign gneg      = gprod_reg[39];
    assign gmag      = gneg ? 40'(-gprod_reg) : 40'(gprod_reg);
    assign ga        = gmag >> 23;
    assign gs        = gneg ? -$signed({1'b0, ga}) : $signed({1'b0, ga});
    assign audio_val = (gs > 41'sd32767) ? 16'sh7fff :
                       ((gs < -41'sd32768) ? 16'sh8000 : gs[15:0]);

    assign dec_eff = (decim_reg == '0) ? 7'd1 :
                     ((decim_reg > fmqd_pkg::DECIM_MAX) ? fmqd_pkg::DECIM_MAX : decim_reg);
    assign cnt_inc = {1'b0, count_reg} + 7'd1;

    assign status.emit_due = (cnt_inc >= dec_eff);
    assign status.out_free = !out_valid_reg || audio.ready;

    assign audio.valid        = out_valid_reg;
    assign audio.audio_sample = out_data_reg;
    assign cfg.ready          = 1'b1;

    always_comb
    begin
        si_next     = si_reg;
        sq_next     = sq_reg;
        sqi_next    = sqi_reg;
        v_next      = v_reg;
        rsq_next    = rsq_reg;
        root_next   = root_reg;
        dsh_next    = dsh_reg;
        remi_next   = remi_reg;
        remq_next   = remq_reg;
        qi_next     = qi_reg;
        qq_next     = qq_reg;
        p1_next     = p1_reg;
        demod_next  = demod_reg;
        prev_i_next = prev_i_reg;
        prev_q_next = prev_q_reg;
        fprod_next  = fprod_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        gprod_next  = gprod_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        gain_next   = gain_reg;
        decim_next  = decim_reg;
        alpha_next  = alpha_reg;

        if (cmd.load)
        begin
            si_next = sample_i[S-1:0];
            sq_next = sample_q[S-1:0];
        end
        if (cmd.pw1)
        begin
            sqi_next = $unsigned(pi);
        end
        if (cmd.pw2)
        begin
            v_next    = {pw_sum, 16'b0};
            rsq_next  = '0;
            root_next = '0;
        end
        if (cmd.sqrt_step)
        begin
            // one root bit per step
            v_next = v_reg << 2;
            if (rem_t >= trial)
            begin
                rsq_next  = (RW+1)'(rem_t - trial);
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rsq_next  = (RW+1)'(rem_t);
                root_next = {root_reg[RW-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            remi_next = num_i + CW'(den >> 1);
            remq_next = num_q + CW'(den >> 1);
            dsh_next  = CW'(den) << (QW - 1);
            qi_next   = '0;
            qq_next   = '0;
        end
        if (cmd.div_step)
        begin
            dsh_next = dsh_reg >> 1;
            if (remi_reg >= dsh_reg)
            begin
                remi_next = remi_reg - dsh_reg;
                qi_next   = {qi_reg[QW-2:0], 1'b1};
            end
            else
            begin
                qi_next = {qi_reg[QW-2:0], 1'b0};
            end
            if (remq_reg >= dsh_reg)
            begin
                remq_next = remq_reg - dsh_reg;
                qq_next   = {qq_reg[QW-2:0], 1'b1};
            end
            else
            begin
                qq_next = {qq_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.mul1)
        begin
            p1_next = m1;
        end
        if (cmd.mul2)
        begin
            demod_next  = DMW'(p1_reg) - DMW'(m2);
            prev_i_next = ni;
            prev_q_next = nq;
        end
        if (cmd.filt1)
        begin
            fprod_next = fm;
        end
        if (cmd.filt2)
        begin
            acc_next   = acc_upd;
            count_next = status.emit_due ? '0 : cnt_inc[fmqd_pkg::COUNT_W-1:0];
        end
        if (cmd.gain)
        begin
            gprod_next = gm;
        end
        if (cmd.emit)
        begin
            out_data_next  = audio_val;
            out_valid_next = 1'b1;
        end
        else if (audio.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg.valid)
        begin
            case (fmqd_pkg::cfg_idx_t'(cfg.index))
                fmqd_pkg::CFG_AUDIO_GAIN:   gain_next  = cfg.data[fmqd_pkg::GAIN_W-1:0];
                fmqd_pkg::CFG_DECIMATION:   decim_next = cfg.data[fmqd_pkg::DECIM_W-1:0];
                fmqd_pkg::CFG_FILTER_ALPHA: alpha_next = cfg.data[fmqd_pkg::ALPHA_W-1:0];
                default:
                begin
                    gain_next = gain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= fmqd_pkg::GAIN_RESET;
            decim_reg     <= fmqd_pkg::DECIM_RESET;
            alpha_reg     <= fmqd_pkg::ALPHA_RESET;
        end
        else
        begin
            prev_i_reg    <= prev_i_next;
            prev_q_reg    <= prev_q_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            gain_reg      <= gain_next;
            decim_reg     <= decim_next;
            alpha_reg     <= alpha_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sq_reg       <= sq_next;
        sqi_reg      <= sqi_next;
        v_reg        <= v_next;
        rsq_reg      <= rsq_next;
        root_reg     <= root_next;
        dsh_reg      <= dsh_next;
        remi_reg     <= remi_next;
        remq_reg     <= remq_next;
        qi_reg       <= qi_next;
        qq_reg       <= qq_next;
        p1_reg       <= p1_next;
        demod_reg    <= demod_next;
        fprod_reg    <= fprod_next;
        gprod_reg    <= gprod_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || audio.ready))
        else $error("audio loaded over an untaken result");

    a_drop_taken: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(audio.ready))
        else $error("audio result dropped before it was taken");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.filt2 |=> $stable(acc_reg))
        else $error("filter state moved outside the update step");

    a_prev_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.mul2 |=> ($stable(prev_i_reg) && $stable(prev_q_reg)))
        else $error("previous limited sample moved outside the discriminator step");
`endif

endmodule

@@ src/fm_quadrature_demodulator.sv @@
// ----------------------------------------------------------------------------
// FM quadrature demodulator
// Conjugate-product FM discriminator with limiter, lowpass and decimation.
// ----------------------------------------------------------------------------
// Channels: samples (sink) takes one raw I/Q request per accepted item;
// audio (source) gives one 16-bit audio request every decimation-th item;
// cfg (sink) writes audio_gain (0), decimation (1) or filter_alpha (2) and
// is always ready; write it only while the block is idle.
// With RW = SAMPLE_BITS + 8 and QW = NORM_FRAC_BITS + 2, the bit-serial square
// root gives an RW-bit root and the two-lane restoring divider QW-bit quotients.
// An item runs the power, root, division, discriminator and lowpass steps, and
// the gain and emit steps only when it yields audio.
// samples.ready is high only while the controller is idle. The audio request
// sits in an output register, so the next sample is taken while it waits; if
// it is still untaken when the following audio is due, the controller holds.
// Reset clears the previous limited sample, the filter state, the decimation
// count and the output valid flag, and loads the default register values.
// ----------------------------------------------------------------------------
module fm_quadrature_demodulator #(
    parameter int SAMPLE_BITS    = 16,
    parameter int NORM_FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    fmqd_in_if.sink     samples,
    fmqd_out_if.source  audio,
    fmqd_cfg_if.sink    cfg
);

    fmqd_pkg::cmd_t    cmd;
    fmqd_pkg::status_t status;
    logic              in_ready;

    assign samples.ready = in_ready;

    fmqd_ctrl #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fmqd_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_i (samples.sample_i),
        .sample_q (samples.sample_q),
        .cmd      (cmd),
        .status   (status),
        .audio    (audio),
        .cfg      (cfg)
    );

endmodule
